[src/cptb_pkg.sv]
// ----------------------------------------------------------------------------
// cptb_pkg
// Shared types, codes and helpers for the cascaded prescaled timer bank.
// ----------------------------------------------------------------------------
package cptb_pkg;

  localparam int CountW     = 16;
  localparam int PrescaleW  = 10;
  localparam int MaskW      = 4;

  localparam int CtrlEnableBit  = 7;
  localparam int CtrlIrqBit     = 6;
  localparam int CtrlCascadeBit = 2;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_WR_CTRL   = 2'd1,
    CMD_WR_RELOAD = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PRE_1    = 2'd0,
    PRE_64   = 2'd1,
    PRE_256  = 2'd2,
    PRE_1024 = 2'd3
  } prescale_t;

  // per-timer command for one item, already qualified by the pipeline advance
  typedef struct packed {
    logic              tick;
    logic              ctrl_wr;
    logic              reload_wr;
    logic [CountW-1:0] data;
  } lane_cmd_t;

  function automatic logic [PrescaleW-1:0] period_mask(input prescale_t sel);
    logic [PrescaleW-1:0] m;
    case (sel)
      PRE_1:    m = '0;
      PRE_64:   m = PrescaleW'(10'h03F);
      PRE_256:  m = PrescaleW'(10'h0FF);
      default:  m = PrescaleW'(10'h3FF);
    endcase
    return m;
  endfunction

endpackage

[src/cptb_lane.sv]
// ----------------------------------------------------------------------------
// cptb_lane
// One 16-bit timer with prescaler, reload and cascade input.
// ----------------------------------------------------------------------------
module cptb_lane (
  input  logic                     clk,
  input  logic                     rst,
  input  cptb_pkg::lane_cmd_t      cmd,
  input  logic                     carry_in,
  output logic                     ovf,
  output logic                     irq,
  output logic [cptb_pkg::CountW-1:0] count
);
  import cptb_pkg::*;

  logic [CountW-1:0]    counter_value;
  logic [CountW-1:0]    reload_value;
  prescale_t            prescale_select;
  logic [PrescaleW-1:0] prescale_count;
  logic                 cascade_mode;
  logic                 irq_enable;
  logic                 timer_on;

  logic [PrescaleW-1:0] prescale_next;
  logic                 step;
  logic                 at_top;

  always_comb begin
    prescale_next = (prescale_count + PrescaleW'(1)) & period_mask(prescale_select);
    step          = timer_on && (cascade_mode ? carry_in : (prescale_next == '0));
    at_top        = (counter_value == '1);
    ovf           = cmd.tick && step && at_top;
    irq           = ovf && irq_enable;
  end

  assign count = counter_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_value   <= '0;
      reload_value    <= '0;
      prescale_select <= PRE_1;
      prescale_count  <= '0;
      cascade_mode    <= 1'b0;
      irq_enable      <= 1'b0;
      timer_on        <= 1'b0;
    end else begin
      if (cmd.tick) begin
        if (timer_on && !cascade_mode) begin
          prescale_count <= prescale_next;
        end
        if (step) begin
          counter_value <= at_top ? reload_value : counter_value + CountW'(1);
        end
      end
      if (cmd.ctrl_wr) begin
        // enable from off restarts the timer
        if (!timer_on && cmd.data[CtrlEnableBit]) begin
          counter_value  <= reload_value;
          prescale_count <= '0;
        end
        prescale_select <= prescale_t'(cmd.data[1:0]);
        cascade_mode    <= cmd.data[CtrlCascadeBit];
        irq_enable      <= cmd.data[CtrlIrqBit];
        timer_on        <= cmd.data[CtrlEnableBit];
      end
      if (cmd.reload_wr) begin
        reload_value <= cmd.data;
      end
    end
  end

endmodule

[src/cascaded_prescaled_timer_bank_unit.sv]
// ----------------------------------------------------------------------------
// cascaded_prescaled_timer_bank_unit
// Bank of cascadable 16-bit timers driven by tick, control, reload and read
// items.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in      | input     | in_valid/in_ready  | cmd, timer_index, data
//   out     | output    | out_valid/out_ready| read_value, overflow_mask, irq_mask
//
// one item per cycle sustained while the output is not stalled; each item passes
// the input register, then the timer update and result register in one pass
// the cascade ripple through all timers settles within the single update cycle
// reset clears all timer state and empties both registers
// a stalled output holds its item; the input register still takes one more
// ----------------------------------------------------------------------------
module cascaded_prescaled_timer_bank_unit #(
  parameter int NUM_TIMERS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [1:0]                    timer_index,
  input  logic [cptb_pkg::CountW-1:0]   data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cptb_pkg::CountW-1:0]   read_value,
  output logic [cptb_pkg::MaskW-1:0]    overflow_mask,
  output logic [cptb_pkg::MaskW-1:0]    irq_mask
);
  import cptb_pkg::*;

  localparam int MaskLanes = (NUM_TIMERS < MaskW) ? NUM_TIMERS : MaskW;

  logic              q_valid;
  cmd_t              q_cmd;
  logic [1:0]        q_index;
  logic [CountW-1:0] q_data;

  logic advance;

  logic              is_tick;
  logic              is_ctrl;
  logic              is_reload;
  logic              is_read;

  lane_cmd_t         lane_cmd   [NUM_TIMERS];
  logic              lane_carry [NUM_TIMERS];
  logic              lane_ovf   [NUM_TIMERS];
  logic              lane_irq   [NUM_TIMERS];
  logic [CountW-1:0] lane_count [NUM_TIMERS];

  logic [CountW-1:0] read_value_next;
  logic [MaskW-1:0]  overflow_mask_next;
  logic [MaskW-1:0]  irq_mask_next;

  assign advance  = q_valid && (!out_valid || out_ready);
  assign in_ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_cmd   <= cmd_t'(cmd);
      q_index <= timer_index;
      q_data  <= data;
    end
  end

  always_comb begin
    is_tick   = 1'b0;
    is_ctrl   = 1'b0;
    is_reload = 1'b0;
    is_read   = 1'b0;
    unique case (q_cmd)
      CMD_TICK:      is_tick   = 1'b1;
      CMD_WR_CTRL:   is_ctrl   = 1'b1;
      CMD_WR_RELOAD: is_reload = 1'b1;
      CMD_READ:      is_read   = 1'b1;
      default:       is_tick   = 1'b0;
    endcase
  end

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_lane
    logic hit;
    assign hit = (int'(q_index) == i);

    assign lane_cmd[i].tick      = advance && is_tick;
    assign lane_cmd[i].ctrl_wr   = advance && is_ctrl && hit;
    assign lane_cmd[i].reload_wr = advance && is_reload && hit;
    assign lane_cmd[i].data      = q_data;

    if (i == 0) begin : g_first
      assign lane_carry[i] = 1'b0;
    end else begin : g_chain
      assign lane_carry[i] = lane_ovf[i-1];
    end

    cptb_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .cmd      (lane_cmd[i]),
      .carry_in (lane_carry[i]),
      .ovf      (lane_ovf[i]),
      .irq      (lane_irq[i]),
      .count    (lane_count[i])
    );
  end

  always_comb begin
    read_value_next    = '0;
    overflow_mask_next = '0;
    irq_mask_next      = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (is_read && int'(q_index) == i) begin
        read_value_next = lane_count[i];
      end
    end
    for (int i = 0; i < MaskLanes; i++) begin
      overflow_mask_next[i] = lane_ovf[i];
      irq_mask_next[i]      = lane_irq[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_value    <= read_value_next;
      overflow_mask <= overflow_mask_next;
      irq_mask      <= irq_mask_next;
    end
  end

endmodule

[src/cptb_checker.sv]
// ----------------------------------------------------------------------------
// cptb_checker
// Port-level checks for the cascaded prescaled timer bank.
// ----------------------------------------------------------------------------
module cptb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cptb_pkg::CountW-1:0] read_value,
  input logic [cptb_pkg::MaskW-1:0]  overflow_mask,
  input logic [cptb_pkg::MaskW-1:0]  irq_mask
);

  // empty output stage never back-pressures the input
  a_ready_when_empty : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output empty");

  // reset empties the output
  a_reset_clears : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output item present after reset");

  // interrupts only on overflowed timers
  a_irq_subset : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((irq_mask & ~overflow_mask) == '0))
    else $error("irq without overflow");

  // a read item with a nonzero value carries no overflow
  a_read_no_ovf : assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_value != '0) |-> (overflow_mask == '0))
    else $error("overflow reported on a read item");

  // stalled output item holds
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(read_value)
      && $stable(overflow_mask) && $stable(irq_mask)))
    else $error("stalled output item changed");

endmodule

bind cascaded_prescaled_timer_bank_unit cptb_checker u_cptb_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .read_value    (read_value),
  .overflow_mask (overflow_mask),
  .irq_mask      (irq_mask)
);

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cascaded prescaled timer bank. A short directed
// sequence walks through enable, overflow, reload, cascade ripple, freeze and
// write-while-on behavior. Random episodes follow: each one sets up a few
// timers with near-wrap reload values and then runs a tick-heavy stream with
// reads and stray writes. An in-bench predictor tracks every timer and checks
// each result in order. Both channels idle at random, and the output side
// holds off for long stretches while the input side keeps offering items.
// ----------------------------------------------------------------------------
module tb_top;
  import cptb_pkg::*;

  localparam int NumTimers  = 4;
  localparam int ItemTarget = 1925;
  localparam int RxHold     = 250;

  typedef struct packed {
    logic [CountW-1:0] rd;
    logic [MaskW-1:0]  ovf;
    logic [MaskW-1:0]  irq;
  } bank_result_t;

  class timer_bank_sb;
    logic [CountW-1:0]    cnt     [NumTimers];
    logic [CountW-1:0]    reload  [NumTimers];
    prescale_t            presel  [NumTimers];
    logic [PrescaleW-1:0] prediv  [NumTimers];
    bit                   cascaded[NumTimers];
    bit                   irq_on  [NumTimers];
    bit                   running [NumTimers];
    bank_result_t         pending_q[$];
    int                   errors;

    function new();
      for (int i = 0; i < NumTimers; i++) begin
        cnt[i] = '0;
        reload[i] = '0;
        presel[i] = PRE_1;
        prediv[i] = '0;
        cascaded[i] = 0;
        irq_on[i] = 0;
        running[i] = 0;
      end
      errors = 0;
    endfunction

    function logic [PrescaleW-1:0] wrap_mask(prescale_t sel);
      int sh;
      sh = (sel == PRE_1) ? 0 : (sel == PRE_64) ? 6 : (sel == PRE_256) ? 8 : 10;
      return PrescaleW'((1 << sh) - 1);
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    task report(string msg);
      if (errors < 50) $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function void note_input(cmd_t op, logic [1:0] idx, logic [CountW-1:0] d);
      bank_result_t r;
      bit carry;
      bit step;
      r = '0;
      case (op)
        CMD_TICK: begin
          carry = 0;
          for (int i = 0; i < NumTimers; i++) begin
            step = 0;
            if (running[i]) begin
              if (cascaded[i]) begin
                step = carry;
              end else begin
                prediv[i] = (prediv[i] + 1'b1) & wrap_mask(presel[i]);
                step = (prediv[i] == '0);
              end
            end
            carry = 0;
            if (step) begin
              cnt[i] = cnt[i] + 1'b1;
              if (cnt[i] == '0) begin
                cnt[i] = reload[i];
                carry = 1;
                r.ovf[i] = 1'b1;
                r.irq[i] = irq_on[i];
              end
            end
          end
        end
        CMD_WR_CTRL: begin
          if (!running[idx] && d[CtrlEnableBit]) begin
            cnt[idx] = reload[idx];
            prediv[idx] = '0;
          end
          presel[idx]   = prescale_t'(d[1:0]);
          cascaded[idx] = d[CtrlCascadeBit];
          irq_on[idx]   = d[CtrlIrqBit];
          running[idx]  = d[CtrlEnableBit];
        end
        CMD_WR_RELOAD: begin
          reload[idx] = d;
        end
        CMD_READ: begin
          r.rd = cnt[idx];
        end
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    task check_result(logic [CountW-1:0] rd, logic [MaskW-1:0] ovf,
                      logic [MaskW-1:0] irq);
      bank_result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("result rd=%h ovf=%b irq=%b with no item pending", rd, ovf, irq));
      end else begin
        want = pending_q.pop_front();
        if (rd !== want.rd)
          report($sformatf("read_value got %h want %h", rd, want.rd));
        if (ovf !== want.ovf)
          report($sformatf("overflow_mask got %b want %b", ovf, want.ovf));
        if (irq !== want.irq)
          report($sformatf("irq_mask got %b want %b", irq, want.irq));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  cmd_t                cmd = CMD_TICK;
  logic [1:0]          timer_index = '0;
  logic [CountW-1:0]   data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CountW-1:0]   read_value;
  logic [MaskW-1:0]    overflow_mask;
  logic [MaskW-1:0]    irq_mask;

  timer_bank_sb sb;
  int  items_sent = 0;
  bit  no_idle = 0;
  bit  hold_out = 0;

  cascaded_prescaled_timer_bank_unit #(.NUM_TIMERS(NumTimers)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .timer_index(timer_index),
    .data(data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_value(read_value),
    .overflow_mask(overflow_mask),
    .irq_mask(irq_mask)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // accepted items and results, sampled at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(cmd, timer_index, data);
      if (out_valid && out_ready) sb.check_result(read_value, overflow_mask, irq_mask);
    end
  end

  function automatic int sender_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(cmd_t op, logic [1:0] idx, logic [CountW-1:0] d);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    timer_index <= idx;
    data <= d;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  function automatic logic [CountW-1:0] rand_reload();
    if ($urandom_range(0, 99) < 70) return 16'hFFFF - 16'($urandom_range(0, 15));
    return 16'($urandom);
  endfunction

  function automatic logic [CountW-1:0] rand_ctrl();
    logic [CountW-1:0] d;
    int p;
    d = 16'($urandom);
    p = $urandom_range(0, 99);
    d[1:0] = (p < 70) ? PRE_1 : (p < 88) ? PRE_64 : (p < 96) ? PRE_256 : PRE_1024;
    d[CtrlEnableBit]  = ($urandom_range(0, 99) < 85);
    d[CtrlCascadeBit] = ($urandom_range(0, 99) < 40);
    return d;
  endfunction

  task automatic run_stream_item();
    int p;
    p = $urandom_range(0, 99);
    if (p < 72)      send_item(CMD_TICK, 2'($urandom), 16'($urandom));
    else if (p < 87) send_item(CMD_READ, 2'($urandom), 16'($urandom));
    else if (p < 94) send_item(CMD_WR_CTRL, 2'($urandom), rand_ctrl());
    else             send_item(CMD_WR_RELOAD, 2'($urandom), rand_reload());
  endtask

  task automatic run_episode();
    int n;
    logic [1:0] idx;
    logic [CountW-1:0] off_ctrl;
    n = $urandom_range(1, 4);
    repeat (n) begin
      idx = 2'($urandom);
      if ($urandom_range(0, 99) < 30) begin
        off_ctrl = 16'($urandom);
        off_ctrl[CtrlEnableBit] = 1'b0;
        send_item(CMD_WR_CTRL, idx, off_ctrl);
      end
      send_item(CMD_WR_RELOAD, idx, rand_reload());
      send_item(CMD_WR_CTRL, idx, rand_ctrl());
    end
    repeat ($urandom_range(5, 60)) run_stream_item();
  endtask

  // receiver: random ready pattern, plus long hold-offs on request
  initial begin
    int run;
    int p;
    bit lvl;
    run = 0;
    lvl = 1;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (RxHold) @(posedge clk);
        hold_out = 0;
        run = 0;
      end else begin
        if (run == 0) begin
          p = $urandom_range(0, 99);
          if (p < 55) begin
            lvl = 1; run = $urandom_range(1, 12);
          end else if (p < 85) begin
            lvl = 0; run = $urandom_range(1, 3);
          end else if (p < 93) begin
            lvl = 0; run = $urandom_range(10, 40);
          end else begin
            lvl = 1; run = $urandom_range(60, 150);
          end
        end
        out_ready <= lvl;
        run--;
      end
    end
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int episode;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset state, single overflow, cascade off then on
    send_item(CMD_READ, 2'd3, 16'h0000);
    send_item(CMD_WR_RELOAD, 2'd0, 16'hFFFE);
    send_item(CMD_WR_RELOAD, 2'd1, 16'hFFFF);
    send_item(CMD_WR_CTRL, 2'd1, 16'h0004);
    send_item(CMD_WR_CTRL, 2'd0, 16'h00C0);
    send_item(CMD_TICK, 2'd0, 16'h0000);
    send_item(CMD_TICK, 2'd3, 16'hFFFF);
    send_item(CMD_WR_CTRL, 2'd1, 16'h00C4);
    send_item(CMD_TICK, 2'd1, 16'h0000);
    send_item(CMD_TICK, 2'd2, 16'h0000);
    // ripple through all four timers in one tick
    send_item(CMD_WR_RELOAD, 2'd2, 16'hFFFF);
    send_item(CMD_WR_CTRL, 2'd2, 16'hFFFF);
    send_item(CMD_WR_RELOAD, 2'd3, 16'hFFFF);
    send_item(CMD_WR_CTRL, 2'd3, 16'h0084);
    send_item(CMD_TICK, 2'd0, 16'h0000);
    send_item(CMD_TICK, 2'd0, 16'h0000);
    // cascade on timer zero never counts
    send_item(CMD_WR_CTRL, 2'd0, 16'h0085);
    send_item(CMD_TICK, 2'd0, 16'h0000);
    // disable freezes, re-enable reloads, write while on keeps count
    send_item(CMD_WR_CTRL, 2'd0, 16'h0041);
    send_item(CMD_TICK, 2'd0, 16'h0000);
    send_item(CMD_READ, 2'd0, 16'hFFFF);
    send_item(CMD_WR_CTRL, 2'd0, 16'h0081);
    send_item(CMD_WR_CTRL, 2'd0, 16'h0083);
    send_item(CMD_READ, 2'd1, 16'h0000);
    send_item(CMD_READ, 2'd2, 16'h0000);

    episode = 0;
    while (items_sent < ItemTarget) begin
      no_idle = ($urandom_range(0, 7) == 0);
      if (episode == 10 || episode == 35) hold_out = 1;
      run_episode();
      episode++;
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
